@@ rtl/core/tea_encrypt_16_rounds_macros.svh @@
// Assertion macros used by the TEA port checker, tea_chk.
`ifndef TEA_ENCRYPT_16_ROUNDS_MACROS_SVH
`define TEA_ENCRYPT_16_ROUNDS_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define TEA_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tea check failed");

// Next-cycle implication, checked outside reset.
`define TEA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tea check failed");

`endif

@@ rtl/core/tea_pkg.sv @@
// Types and constants shared by the TEA encryption pipeline.
`default_nettype none

package tea_pkg;

	typedef logic [31:0] word_t;

	typedef struct packed {
		word_t y;
		word_t z;
	} blk_t;

	localparam word_t DELTA = 32'h9E37_79B9;

	localparam int KEY_IDX_W = 2;
	typedef logic [KEY_IDX_W-1:0] key_idx_t;

	localparam key_idx_t KEY_W0 = 2'd0;
	localparam key_idx_t KEY_W1 = 2'd1;
	localparam key_idx_t KEY_W2 = 2'd2;
	localparam key_idx_t KEY_W3 = 2'd3;

endpackage

`default_nettype wire

@@ rtl/core/tea_skid.sv @@
// Input skid stage: holds one word while the pipeline is frozen.
`default_nettype none

module tea_skid (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          plain_valid,
	input  wire tea_pkg::blk_t plain_blk,
	output logic               stall,
	output logic               src_valid,
	output tea_pkg::blk_t      src_blk
);

	logic          skid_v_q;
	tea_pkg::blk_t skid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_v_q <= 1'b0;
		end else if (en) begin
			skid_v_q <= 1'b0;
		end else if (plain_valid && !skid_v_q) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!en && plain_valid && !skid_v_q) begin
			skid_q <= plain_blk;
		end
	end

	assign stall     = skid_v_q;
	assign src_valid = skid_v_q | plain_valid;
	assign src_blk   = skid_v_q ? skid_q : plain_blk;

endmodule

`default_nettype wire

@@ rtl/core/tea_cell.sv @@
// One half round of TEA: updates either the y or the z word, registered.
`default_nettype none

module tea_cell #(
	parameter bit          UPD_Y = 1'b1,
	parameter logic [31:0] SUM   = 32'h9E37_79B9
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          valid_i,
	input  wire tea_pkg::blk_t blk_i,
	input  wire tea_pkg::word_t key_a,
	input  wire tea_pkg::word_t key_b,
	output logic               valid_q,
	output tea_pkg::blk_t      blk_q
);

	tea_pkg::word_t src;
	tea_pkg::word_t mix;
	tea_pkg::blk_t  nxt;

	always_comb begin
		src = UPD_Y ? blk_i.z : blk_i.y;
		mix = ((src << 4) + key_a) ^ (src + SUM) ^ ((src >> 5) + key_b);
		nxt = blk_i;
		if (UPD_Y) begin
			nxt.y = blk_i.y + mix;
		end else begin
			nxt.z = blk_i.z + mix;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			blk_q <= nxt;
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/tea_encrypt_16_rounds.sv @@
// TEA encryption: 2*ROUNDS half-round cells, one block per cycle if not held.
//
// Plain channel: plain_valid with plain_hi/plain_lo; a word is taken at a
// clock edge with plain_valid high and plain_stall low.
// Cipher channel: cipher_valid with cipher_hi/cipher_lo; the receiver holds
// cipher_stall high to keep the word in place.
// Key port: cfg_valid/cfg_ready with cfg_index (0..3) and cfg_data; cfg_ready
// is always high. The user changes keys only while no block is in flight;
// the block does not enforce this. The 2*ROUNDS cells (32 at ROUNDS=16) are
// register stages; one block enters per cycle while the chain is not frozen.
// A stall of a valid cipher word freezes the whole chain; one more word is
// then caught in the input skid, after which plain_stall goes high until the
// chain moves. Reset clears all valid bits and the key words to zero.
`default_nettype none

module tea_encrypt_16_rounds #(
	parameter int ROUNDS = 16
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      plain_valid,
	output logic                           plain_stall,
	input  wire logic [31:0]               plain_hi,
	input  wire logic [31:0]               plain_lo,
	output logic                           cipher_valid,
	input  wire logic                      cipher_stall,
	output logic [31:0]                    cipher_hi,
	output logic [31:0]                    cipher_lo,
	input  wire logic                      cfg_valid,
	output logic                           cfg_ready,
	input  wire tea_pkg::key_idx_t         cfg_index,
	input  wire logic [31:0]               cfg_data
);

	localparam int CELLS = 2 * ROUNDS;

	tea_pkg::word_t key0_q, key1_q, key2_q, key3_q;

	logic          en;
	logic          v   [0:CELLS];
	tea_pkg::blk_t b   [0:CELLS];
	tea_pkg::blk_t plain_blk;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key0_q <= '0;
			key1_q <= '0;
			key2_q <= '0;
			key3_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				tea_pkg::KEY_W0: key0_q <= cfg_data;
				tea_pkg::KEY_W1: key1_q <= cfg_data;
				tea_pkg::KEY_W2: key2_q <= cfg_data;
				tea_pkg::KEY_W3: key3_q <= cfg_data;
			endcase
		end
	end

	// whole chain advances unless the output word is held
	assign en = !(v[CELLS] && cipher_stall);

	assign plain_blk.y = plain_hi;
	assign plain_blk.z = plain_lo;

	tea_skid u_skid (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.plain_valid (plain_valid),
		.plain_blk   (plain_blk),
		.stall       (plain_stall),
		.src_valid   (v[0]),
		.src_blk     (b[0])
	);

	for (genvar i = 0; i < CELLS; i++) begin : g_cell
		localparam logic [63:0] SUM_W = 64'(tea_pkg::DELTA) * 64'(i / 2 + 1);
		localparam bit          UPD_Y = ((i % 2) == 0);

		tea_cell #(
			.UPD_Y (UPD_Y),
			.SUM   (SUM_W[31:0])
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.valid_i (v[i]),
			.blk_i   (b[i]),
			.key_a   (UPD_Y ? key0_q : key2_q),
			.key_b   (UPD_Y ? key1_q : key3_q),
			.valid_q (v[i+1]),
			.blk_q   (b[i+1])
		);
	end

	assign cipher_valid = v[CELLS];
	assign cipher_hi    = b[CELLS].y;
	assign cipher_lo    = b[CELLS].z;

endmodule

`default_nettype wire

@@ rtl/core/tea_chk.sv @@
// Port-level checks for the TEA encryption block, bound to the top level.
`default_nettype none
`include "tea_encrypt_16_rounds_macros.svh"

module tea_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        plain_valid,
	input wire logic        plain_stall,
	input wire logic        cipher_valid,
	input wire logic        cipher_stall,
	input wire logic [31:0] cipher_hi,
	input wire logic [31:0] cipher_lo
);

	// a held output word keeps its value
	`TEA_ASSERT_NEXT(a_hold, clk, arst_n, cipher_valid && cipher_stall,
		cipher_valid && $stable(cipher_hi) && $stable(cipher_lo))

	// the skid takes only one word while the output is held
	`TEA_ASSERT_NEXT(a_skid_fill, clk, arst_n,
		cipher_valid && cipher_stall && plain_valid && !plain_stall, plain_stall)

	// input backpressure only ever comes from a waiting output word
	`TEA_ASSERT_NOW(a_stall_cause, clk, arst_n, plain_stall, cipher_valid)

endmodule

bind tea_encrypt_16_rounds tea_chk u_tea_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.plain_valid  (plain_valid),
	.plain_stall  (plain_stall),
	.cipher_valid (cipher_valid),
	.cipher_stall (cipher_stall),
	.cipher_hi    (cipher_hi),
	.cipher_lo    (cipher_lo)
);

`default_nettype wire

@@ tb/tea_encrypt_16_rounds_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for the TEA pipeline: follows key writes, predicts ciphertext words, checks output.
module tea_encrypt_16_rounds_checker
	import tea_pkg::*;
#(
	parameter int ROUNDS = 16
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     plain_valid,
	input  wire logic     plain_stall,
	input  wire logic [31:0] plain_hi,
	input  wire logic [31:0] plain_lo,
	input  wire logic     cipher_valid,
	input  wire logic     cipher_stall,
	input  wire logic [31:0] cipher_hi,
	input  wire logic [31:0] cipher_lo,
	input  wire logic     cfg_valid,
	input  wire logic     cfg_ready,
	input  wire key_idx_t cfg_index,
	input  wire logic [31:0] cfg_data,
	input  wire logic     at_end,
	output int            errors,
	output int            pending,
	output int            blocks_in,
	output int            blocks_out
);

	localparam int MAX_REPORTS = 10;

	word_t key_w [4];
	blk_t  expected_cipher [$];
	int    mismatches;
	int    n_in;
	int    n_out;

	// Straight 16-round TEA under the tracked key, all sums wrap at 32 bits.
	function automatic blk_t encrypt_block(input blk_t pt);
		word_t y;
		word_t z;
		word_t sum;
		y = pt.y;
		z = pt.z;
		sum = DELTA;
		for (int r = 0; r < ROUNDS; r++) begin
			y += ((z << 4) + key_w[KEY_W0]) ^ (z + sum) ^ ((z >> 5) + key_w[KEY_W1]);
			z += ((y << 4) + key_w[KEY_W2]) ^ (y + sum) ^ ((y >> 5) + key_w[KEY_W3]);
			sum += DELTA;
		end
		return '{y: y, z: z};
	endfunction

	always @(posedge clk or negedge arst_n) begin
		blk_t want;
		logic bad_hi;
		logic bad_lo;
		if (!arst_n) begin
			foreach (key_w[i]) key_w[i] = '0;
			expected_cipher.delete();
			mismatches = 0;
			n_in = 0;
			n_out = 0;
			errors <= 0;
			pending <= 0;
			blocks_in <= 0;
			blocks_out <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
				KEY_W0: key_w[KEY_W0] = cfg_data;
				KEY_W1: key_w[KEY_W1] = cfg_data;
				KEY_W2: key_w[KEY_W2] = cfg_data;
				KEY_W3: key_w[KEY_W3] = cfg_data;
				default: ;
				endcase
			end

			if (cipher_valid && !cipher_stall) begin
				n_out++;
				if (expected_cipher.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("cipher word %0d with nothing expected: hi=%h lo=%h",
							n_out, cipher_hi, cipher_lo);
				end else begin
					want = expected_cipher.pop_front();
					bad_hi = (cipher_hi !== want.y);
					bad_lo = (cipher_lo !== want.z);
					if (bad_hi || bad_lo) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS)
							$display("cipher word %0d: hi exp %h got %h%s, lo exp %h got %h%s",
								n_out, want.y, cipher_hi, bad_hi ? " (bad)" : "",
								want.z, cipher_lo, bad_lo ? " (bad)" : "");
					end
				end
			end

			if (plain_valid && !plain_stall) begin
				n_in++;
				expected_cipher.push_back(encrypt_block('{y: plain_hi, z: plain_lo}));
			end

			// words still owed at the end of the run count as failures
			errors <= mismatches + (at_end ? expected_cipher.size() : 0);
			pending <= expected_cipher.size();
			blocks_in <= n_in;
			blocks_out <= n_out;
		end
	end

endmodule

@@ tb/tb_tea_encrypt_16_rounds.sv @@
`timescale 1ns / 1ps
// Testbench top for the TEA encryption pipeline: stimulus, key phases and verdict.
module tb_tea_encrypt_16_rounds;
	import tea_pkg::*;

	localparam int ROUNDS = 16;
	localparam int LATENCY = 2 * ROUNDS;
	localparam int CYCLE_LIMIT = 400000;
	localparam int KEY_PHASES = 7;
	localparam int RANDOM_PER_PHASE = 140;

	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_RANDOM,
		STALL_LONG,
		STALL_PERIODIC
	} stall_mode_e;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     plain_valid = 1'b0;
	logic     plain_stall;
	word_t    plain_hi = '0;
	word_t    plain_lo = '0;
	logic     cipher_valid;
	logic     cipher_stall = 1'b0;
	word_t    cipher_hi;
	word_t    cipher_lo;
	logic     cfg_valid = 1'b0;
	logic     cfg_ready;
	key_idx_t cfg_index = KEY_W0;
	word_t    cfg_data = '0;
	logic     at_end = 1'b0;

	int errors;
	int pending;
	int blocks_in;
	int blocks_out;
	int cycles = 0;
	int burst_left = 0;
	int key_settings = 1;

	stall_mode_e stall_mode = STALL_NONE;
	int          mode_left = 0;
	int          run_left = 0;
	logic [2:0]  period_cnt = '0;

	always #5 clk = ~clk;

	tea_encrypt_16_rounds #(
		.ROUNDS(ROUNDS)
	) DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.plain_valid (plain_valid),
		.plain_stall (plain_stall),
		.plain_hi    (plain_hi),
		.plain_lo    (plain_lo),
		.cipher_valid(cipher_valid),
		.cipher_stall(cipher_stall),
		.cipher_hi   (cipher_hi),
		.cipher_lo   (cipher_lo),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	tea_encrypt_16_rounds_checker #(
		.ROUNDS(ROUNDS)
	) u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.plain_valid (plain_valid),
		.plain_stall (plain_stall),
		.plain_hi    (plain_hi),
		.plain_lo    (plain_lo),
		.cipher_valid(cipher_valid),
		.cipher_stall(cipher_stall),
		.cipher_hi   (cipher_hi),
		.cipher_lo   (cipher_lo),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.at_end      (at_end),
		.errors      (errors),
		.pending     (pending),
		.blocks_in   (blocks_in),
		.blocks_out  (blocks_out)
	);

	// Receiver back-pressure: switches between free-running, sparse random,
	// long stall runs and a fixed period.
	always @(negedge clk) begin
		period_cnt <= period_cnt + 3'd1;
		if (mode_left == 0) begin
			stall_mode <= stall_mode_e'($urandom_range(0, 3));
			mode_left <= $urandom_range(20, 300);
		end else begin
			mode_left <= mode_left - 1;
		end
		case (stall_mode)
		STALL_NONE: cipher_stall <= 1'b0;
		STALL_RANDOM: cipher_stall <= ($urandom_range(0, 3) == 0);
		STALL_LONG: begin
			if (run_left == 0) begin
				cipher_stall <= ~cipher_stall;
				run_left <= $urandom_range(1, 20);
			end else begin
				run_left <= run_left - 1;
			end
		end
		STALL_PERIODIC: cipher_stall <= (period_cnt == 3'd5 || period_cnt == 3'd6);
		default: cipher_stall <= 1'b0;
		endcase
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d words still owed", cycles, pending);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Mostly full-range words, with zeros, all ones, single-bit and single-clear-bit patterns mixed in.
	function automatic word_t pick_word();
		case ($urandom_range(0, 9))
		0: return 32'h0000_0000;
		1: return 32'hFFFF_FFFF;
		2: return 32'h1 << $urandom_range(0, 31);
		3: return ~(32'h1 << $urandom_range(0, 31));
		default: return $urandom();
		endcase
	endfunction

	// One plain word; burst and gap lengths are drawn here.
	task automatic send_block(input word_t hi, input word_t lo);
		int gap;
		@(negedge clk);
		plain_valid <= 1'b1;
		plain_hi <= hi;
		plain_lo <= lo;
		do @(posedge clk); while (plain_stall);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
				: $urandom_range(0, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				@(negedge clk);
				plain_valid <= 1'b0;
				plain_hi <= $urandom();
				plain_lo <= $urandom();
				repeat (gap - 1) @(negedge clk);
			end
		end
	endtask

	task automatic send_random(input int count);
		repeat (count) send_block(pick_word(), pick_word());
	endtask

	// Drop valid and wait for every owed cipher word before touching the key.
	task automatic drain();
		@(negedge clk);
		plain_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic load_key(input word_t k0, input word_t k1, input word_t k2, input word_t k3);
		word_t    kw [4];
		key_idx_t order [4];
		kw = '{k0, k1, k2, k3};
		order = '{KEY_W0, KEY_W1, KEY_W2, KEY_W3};
		foreach (order[i]) begin
			@(negedge clk);
			cfg_valid <= 1'b1;
			cfg_index <= order[i];
			cfg_data <= kw[i];
			do @(posedge clk); while (!cfg_ready);
		end
		@(negedge clk);
		cfg_valid <= 1'b0;
		key_settings++;
	endtask

	initial begin
		blk_t  corner [16];
		word_t key_table [KEY_PHASES][4];
		corner = '{
			64'h0000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF,
			64'h0000_0000_FFFF_FFFF, 64'hFFFF_FFFF_0000_0000,
			64'h8000_0000_0000_0000, 64'h0000_0000_8000_0000,
			64'h0000_0001_0000_0000, 64'h0000_0000_0000_0001,
			64'h7FFF_FFFF_7FFF_FFFF, 64'hAAAA_AAAA_5555_5555,
			64'h5555_5555_AAAA_AAAA, 64'h0123_4567_89AB_CDEF,
			64'h0000_000F_0000_0000, 64'h0000_0000_0000_001F,
			64'h0000_0000_0000_0020, 64'hF000_0000_0F00_0000
		};
		key_table[0] = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
		key_table[1] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF};
		key_table[2] = '{32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000};
		key_table[3] = '{32'h0123_4567, 32'h89AB_CDEF, 32'hFEDC_BA98, 32'h7654_3210};
		for (int p = 4; p < KEY_PHASES; p++)
			key_table[p] = '{$urandom(), $urandom(), $urandom(), $urandom()};

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// key left at its reset value of zero
		foreach (corner[i]) send_block(corner[i].y, corner[i].z);
		send_random(90);
		drain();

		for (int p = 0; p < KEY_PHASES; p++) begin
			load_key(key_table[p][0], key_table[p][1], key_table[p][2], key_table[p][3]);
			if (p == 0)
				for (int i = 0; i < 8; i++) send_block(corner[i].y, corner[i].z);
			send_random(RANDOM_PER_PHASE);
			drain();
		end

		repeat (LATENCY) @(posedge clk);
		@(negedge clk);
		at_end <= 1'b1;
		repeat (2) @(posedge clk);

		$display("Encrypted %0d blocks under %0d keys, %0d cipher words checked.",
			blocks_in, key_settings, blocks_out);
		$display("Keys: reset zero, all ones, alternating extremes, fixed and random words.");
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
